[rtl/core/kmc_pkg.sv]
// Shared types, codes and widths of the k-means clustering engine.
// Used by kmc_div and kmeans_clustering; depends on nothing.
package kmc_pkg;

  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_MAX_DIMS     = 16;
  localparam int DEF_MAX_CLUSTERS = 16;

  localparam int COORD_W    = 16;
  localparam int SQ_W       = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 88;

  localparam logic [SQ_W-1:0] SQ_LIMIT = '1;

  localparam logic [2:0] OP_WR_POINT = 3'd0;
  localparam logic [2:0] OP_WR_CENT  = 3'd1;
  localparam logic [2:0] OP_RUN      = 3'd2;
  localparam logic [2:0] OP_RD_CLASS = 3'd3;
  localparam logic [2:0] OP_RD_CENT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_THR    = 3'd5;

  localparam logic [1:0] REASON_CHANGES = 2'd0;
  localparam logic [1:0] REASON_ITER    = 2'd1;
  localparam logic [1:0] REASON_SHIFT   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_OUT,
    S_A_ISSUE, S_A_MUL, S_A_ACC, S_A_CLS,
    S_U_ISSUE, S_U_ACC, S_U_DIV, S_U_WAIT, S_U_MUL, S_U_SH,
    S_STOP
  } state_t;

  typedef enum logic [1:0] {
    K_ZERO, K_CLASS, K_CENT, K_RUN
  } kind_t;

endpackage

[rtl/core/kmc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/kmc_div.sv]
// Radix-2 restoring divider, signed dividend by unsigned divisor, quotient
// truncated toward zero. Depends on kmc_pkg.
module kmc_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]             den,
  output logic                         done,
  output logic signed [kmc_pkg::COORD_W-1:0] quo
);
  import kmc_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    count;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_sh;
  logic [NUM_W-1:0] q;
  logic [NUM_W-1:0] q_signed;
  logic             neg;

  assign rem_sh   = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign q_signed = neg ? (~q + 1'b1) : q;
  assign quo      = COORD_W'(q_signed);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        neg   <= num[NUM_W-1];
        q     <= num[NUM_W-1] ? (~num + 1'b1) : num;
        rem   <= '0;
        count <= CW'(NUM_W);
      end else if (busy) begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");

endmodule

[rtl/core/kmeans_clustering.sv]
// Lloyd k-means clustering engine, top level: sequencer, stores and the
// shared square unit. Depends on kmc_pkg, kmc_ram and kmc_div.
//
// Load point and centroid coordinates (signed Q8.8) with write items, start a
// run with a run item and fetch classes or centroids with read items. Write
// items are done as they are taken; read items pass through S_RD and S_OUT
// and wait in S_OUT on the result side. After reset, and at the start of
// every run, the class map is cleared, and no item is taken meanwhile.
// Each iteration of a run has an assignment pass, driven by the single 17x17
// square unit reading one point and one centroid coordinate per step, and a
// mean pass, paced by the walk over the point memory and the bit-serial
// divider (NUM_W is 27 by default). An empty cluster skips its mean pass
// after one walk. The result of a run carries the iteration count, the last
// change count, the stop reason and the largest squared centroid shift.
module kmeans_clustering #(
  parameter int MAX_POINTS   = kmc_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS     = kmc_pkg::DEF_MAX_DIMS,
  parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // operation[2:0], item_index[12:3], dim_index[16:13], coord_value[32:17]
  input  logic [kmc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // read_value[15:0], iterations_done[31:16], last_changes[42:32],
  // stop_reason[44:43], max_shift_sq[80:45]
  output logic [kmc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kmc_pkg::*;

  localparam int PSD  = MAX_POINTS * MAX_DIMS;
  localparam int PAW  = (PSD > 1) ? $clog2(PSD) : 1;
  localparam int CSD  = MAX_CLUSTERS * MAX_DIMS;
  localparam int CAW  = (CSD > 1) ? $clog2(CSD) : 1;
  localparam int PIW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NPW  = $clog2(MAX_POINTS + 1);
  localparam int CLW  = $clog2(MAX_CLUSTERS + 1);
  localparam int SUMW = COORD_W + $clog2(MAX_POINTS) + 1;
  localparam int PRODW = 2 * (COORD_W + 1);
  localparam int ACCW = PRODW + $clog2(MAX_DIMS) + 1;

  // Input fields
  logic [2:0]                op;
  logic [9:0]                item;
  logic [3:0]                dim;
  logic [COORD_W-1:0]        val;
  assign op   = s_tdata[2:0];
  assign item = s_tdata[12:3];
  assign dim  = s_tdata[16:13];
  assign val  = s_tdata[32:17];

  // Configuration registers, held raw and clamped on use
  logic [10:0]     cfg_np;
  logic [4:0]      cfg_nd;
  logic [4:0]      cfg_nk;
  logic [15:0]     cfg_max_iter;
  logic [10:0]     cfg_min_chg;
  logic [SQ_W-1:0] cfg_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_np       <= 11'd1;
      cfg_nd       <= 5'd1;
      cfg_nk       <= 5'd1;
      cfg_max_iter <= 16'd1;
      cfg_min_chg  <= '0;
      cfg_thr      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS:   cfg_np       <= cfg_data[10:0];
        CFG_NUM_DIMS:     cfg_nd       <= cfg_data[4:0];
        CFG_NUM_CLUSTERS: cfg_nk       <= cfg_data[4:0];
        CFG_MAX_ITER:     cfg_max_iter <= cfg_data[15:0];
        CFG_MIN_CHANGES:  cfg_min_chg  <= cfg_data[10:0];
        CFG_SHIFT_THR:    cfg_thr      <= cfg_data[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Last valid index of each loop, after clamping to 1..MAX
  logic [PIW-1:0] np_last;
  logic [KW-1:0]  nk_last;
  logic [DW-1:0]  nd_last;
  always_comb begin
    if (cfg_np == '0)                   np_last = '0;
    else if (32'(cfg_np) > MAX_POINTS)  np_last = PIW'(MAX_POINTS - 1);
    else                                np_last = PIW'(32'(cfg_np) - 1);
    if (cfg_nk == '0)                   nk_last = '0;
    else if (32'(cfg_nk) > MAX_CLUSTERS) nk_last = KW'(MAX_CLUSTERS - 1);
    else                                nk_last = KW'(32'(cfg_nk) - 1);
    if (cfg_nd == '0)                   nd_last = '0;
    else if (32'(cfg_nd) > MAX_DIMS)    nd_last = DW'(MAX_DIMS - 1);
    else                                nd_last = DW'(32'(cfg_nd) - 1);
  end

  // Sequencer registers
  state_t               state, state_next;
  logic [PIW-1:0]       pi;
  logic [KW-1:0]        kj;
  logic [DW-1:0]        dd;
  logic [ACCW-1:0]      acc;
  logic [PRODW-1:0]     prod;
  logic [SQ_W-1:0]      best;
  logic [KW-1:0]        bestj;
  logic [NPW-1:0]       changes;
  logic [15:0]          it;
  logic signed [SUMW-1:0] sum;
  logic [NPW-1:0]       cnt;
  logic [SQ_W-1:0]      maxsh;
  logic signed [COORD_W-1:0] mean;
  logic                 run_pending;
  kind_t                rd_kind;
  logic [PIW-1:0]       rd_item;
  logic [CAW-1:0]       rd_caddr;
  logic [15:0]          res_iter;
  logic [10:0]          res_changes;
  logic [1:0]           res_reason;
  logic [SQ_W-1:0]      res_maxsh;

  // Store ports
  logic               pt_we, ce_we, cl_we;
  logic [PAW-1:0]     pt_raddr;
  logic [CAW-1:0]     ce_raddr, ce_waddr;
  logic [COORD_W-1:0] ce_wdata, pt_rdata, ce_rdata;
  logic [PIW-1:0]     cl_raddr;
  logic [CLW-1:0]     cl_wdata, cl_rdata;

  // Address arithmetic
  logic           item_ok_p, item_ok_c, dim_ok;
  logic [PAW-1:0] in_paddr, run_paddr;
  logic [CAW-1:0] in_caddr, run_caddr;
  assign item_ok_p = 32'(item) < MAX_POINTS;
  assign item_ok_c = 32'(item) < MAX_CLUSTERS;
  assign dim_ok    = 32'(dim) < MAX_DIMS;
  assign in_paddr  = PAW'(32'(item) * MAX_DIMS + 32'(dim));
  assign in_caddr  = CAW'(32'(item) * MAX_DIMS + 32'(dim));
  assign run_paddr = PAW'(32'(pi) * MAX_DIMS + 32'(dd));
  assign run_caddr = CAW'(32'(kj) * MAX_DIMS + 32'(dd));

  // Shared square unit
  logic signed [COORD_W:0]  mdiff;
  logic signed [PRODW-1:0]  mprod;
  assign mprod = mdiff * mdiff;

  // Divider
  logic                      div_start;
  logic                      div_done;
  logic signed [COORD_W-1:0] div_q;

  logic [CLW-1:0]  new_cls;
  logic [ACCW-1:0] acc_next;
  logic [SQ_W-1:0] acc_sat;
  logic [16:0]     it_inc;
  logic            stop_chg, stop_iter, stop_shift, out_free;

  assign new_cls    = CLW'(bestj) + 1'b1;
  assign acc_next   = acc + ACCW'(prod);
  assign acc_sat    = (acc_next > ACCW'(SQ_LIMIT)) ? SQ_LIMIT : acc_next[SQ_W-1:0];
  assign it_inc     = {1'b0, it} + 17'd1;
  assign stop_chg   = 32'(changes) <= 32'(cfg_min_chg);
  assign stop_iter  = it_inc >= {1'b0, cfg_max_iter};
  assign stop_shift = maxsh <= cfg_thr;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    pt_we         = 1'b0;
    ce_we         = 1'b0;
    cl_we         = 1'b0;
    div_start     = 1'b0;
    cl_wdata      = '0;
    cl_raddr      = pi;
    pt_raddr      = run_paddr;
    ce_raddr      = run_caddr;
    ce_waddr      = run_caddr;
    ce_wdata      = mean;
    mdiff         = '0;
    unique case (state)
      S_CLEAR: begin
        cl_we = 1'b1;
        if (pi == PIW'(MAX_POINTS - 1)) state_next = run_pending ? S_A_ISSUE : S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          case (op) inside
            OP_WR_POINT: pt_we = dim_ok && item_ok_p;
            OP_WR_CENT: begin
              ce_we    = dim_ok && item_ok_c;
              ce_waddr = in_caddr;
              ce_wdata = val;
            end
            OP_RUN: state_next = S_CLEAR;
            OP_RD_CLASS, OP_RD_CENT: state_next = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: begin
        cl_raddr   = rd_item;
        ce_raddr   = rd_caddr;
        state_next = S_OUT;
      end
      S_OUT: begin
        cl_raddr = rd_item;
        ce_raddr = rd_caddr;
        if (out_free) state_next = S_IDLE;
      end
      S_A_ISSUE: state_next = S_A_MUL;
      S_A_MUL: begin
        mdiff      = (COORD_W+1)'($signed(pt_rdata)) - (COORD_W+1)'($signed(ce_rdata));
        state_next = S_A_ACC;
      end
      S_A_ACC: state_next = (dd == nd_last && kj == nk_last) ? S_A_CLS : S_A_ISSUE;
      S_A_CLS: begin
        cl_we      = 1'b1;
        cl_wdata   = new_cls;
        state_next = (pi == np_last) ? S_U_ISSUE : S_A_ISSUE;
      end
      S_U_ISSUE: state_next = S_U_ACC;
      S_U_ACC:   state_next = (pi == np_last) ? S_U_DIV : S_U_ISSUE;
      S_U_DIV: begin
        if (cnt == '0) begin
          state_next = (kj == nk_last) ? S_STOP : S_U_ISSUE;
        end else begin
          div_start  = 1'b1;
          state_next = S_U_WAIT;
        end
      end
      S_U_WAIT: if (div_done) state_next = S_U_MUL;
      S_U_MUL: begin
        mdiff      = (COORD_W+1)'($signed(ce_rdata)) - (COORD_W+1)'(mean);
        ce_we      = 1'b1;
        state_next = S_U_SH;
      end
      S_U_SH: begin
        if (dd == nd_last && kj == nk_last) state_next = S_STOP;
        else                                state_next = S_U_ISSUE;
      end
      S_STOP: state_next = (stop_chg || stop_iter || stop_shift) ? S_OUT : S_A_ISSUE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pi          <= '0;
      run_pending <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // Load the result register when it is free, drop valid after the transfer
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)              m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (pi == PIW'(MAX_POINTS - 1)) begin
            pi          <= '0;
            kj          <= '0;
            dd          <= '0;
            acc         <= '0;
            changes     <= '0;
            it          <= '0;
            run_pending <= 1'b0;
          end else begin
            pi <= pi + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            rd_item  <= item_ok_p ? PIW'(item) : '0;
            rd_caddr <= in_caddr;
            if (op == OP_RD_CLASS) rd_kind <= item_ok_p ? K_CLASS : K_ZERO;
            if (op == OP_RD_CENT)  rd_kind <= (item_ok_c && dim_ok) ? K_CENT : K_ZERO;
            if (op == OP_RUN) begin
              run_pending <= 1'b1;
              pi          <= '0;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            case (rd_kind)
              K_CLASS: m_tdata <= OUT_TDATA_W'(cl_rdata);
              K_CENT:  m_tdata <= OUT_TDATA_W'(ce_rdata);
              K_RUN:   m_tdata <= OUT_TDATA_W'({res_maxsh, res_reason, res_changes,
                                                res_iter, 16'd0});
              default: m_tdata <= '0;
            endcase
          end
        end
        S_A_MUL: prod <= mprod;
        S_A_ACC: begin
          if (dd == nd_last) begin
            dd  <= '0;
            acc <= '0;
            if (kj == '0 || acc_sat < best) begin
              best  <= acc_sat;
              bestj <= kj;
            end
            if (kj != nk_last) kj <= kj + 1'b1;
          end else begin
            dd  <= dd + 1'b1;
            acc <= acc_next;
          end
        end
        S_A_CLS: begin
          if (cl_rdata != new_cls) changes <= changes + 1'b1;
          kj <= '0;
          if (pi == np_last) begin
            pi    <= '0;
            dd    <= '0;
            sum   <= '0;
            cnt   <= '0;
            acc   <= '0;
            maxsh <= '0;
          end else begin
            pi <= pi + 1'b1;
          end
        end
        S_U_ACC: begin
          if (cl_rdata == CLW'(kj) + 1'b1) begin
            sum <= sum + SUMW'($signed(pt_rdata));
            cnt <= cnt + 1'b1;
          end
          pi <= (pi == np_last) ? '0 : pi + 1'b1;
        end
        S_U_DIV: begin
          // Empty cluster: keep the centroid, zero shift, move on
          if (cnt == '0) begin
            dd  <= '0;
            acc <= '0;
            if (kj != nk_last) kj <= kj + 1'b1;
          end
        end
        S_U_WAIT: if (div_done) mean <= div_q;
        S_U_MUL: prod <= mprod;
        S_U_SH: begin
          sum <= '0;
          cnt <= '0;
          if (dd == nd_last) begin
            dd  <= '0;
            acc <= '0;
            if (acc_sat > maxsh) maxsh <= acc_sat;
            if (kj != nk_last) kj <= kj + 1'b1;
          end else begin
            dd  <= dd + 1'b1;
            acc <= acc_next;
          end
        end
        S_STOP: begin
          it <= it_inc[15:0];
          if (stop_chg || stop_iter || stop_shift) begin
            rd_kind     <= K_RUN;
            res_iter    <= it_inc[15:0];
            res_changes <= 11'(changes);
            res_maxsh   <= maxsh;
            if (stop_chg)       res_reason <= REASON_CHANGES;
            else if (stop_iter) res_reason <= REASON_ITER;
            else                res_reason <= REASON_SHIFT;
          end else begin
            changes <= '0;
            pi      <= '0;
            kj      <= '0;
            dd      <= '0;
            acc     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  kmc_ram #(.WIDTH(COORD_W), .DEPTH(PSD), .AW(PAW)) u_point_ram (
    .clk(clk), .we(pt_we), .waddr(in_paddr), .wdata(val),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  kmc_ram #(.WIDTH(COORD_W), .DEPTH(CSD), .AW(CAW)) u_cent_ram (
    .clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(ce_wdata),
    .raddr(ce_raddr), .rdata(ce_rdata)
  );

  kmc_ram #(.WIDTH(CLW), .DEPTH(MAX_POINTS), .AW(PIW)) u_class_ram (
    .clk(clk), .we(cl_we), .waddr(pi), .wdata(cl_wdata),
    .raddr(cl_raddr), .rdata(cl_rdata)
  );

  kmc_div #(.NUM_W(SUMW), .DEN_W(NPW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum), .den(cnt),
    .done(div_done), .quo(div_q)
  );

  assert property (@(posedge clk) disable iff (rst) div_start |-> cnt != '0)
    else $error("mean started for an empty cluster");
  assert property (@(posedge clk) disable iff (rst)
      state == S_CLEAR |-> cl_we && cl_wdata == '0)
    else $error("class clear pass wrote a nonzero class");
  assert property (@(posedge clk) disable iff (rst)
      state == S_A_CLS |-> cl_wdata != '0)
    else $error("assignment wrote class zero");
  assert property (@(posedge clk) disable iff (rst)
      state == S_STOP |=> state == S_OUT || state == S_A_ISSUE)
    else $error("run did not stop or iterate");

endmodule
